// ===== src/fevad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fevad_pkg
// Shared constants, types and helpers of the frame energy voice detector.
// ----------------------------------------------------------------------------
package fevad_pkg;

    // sample format and frame size
    localparam int SAMPLE_BITS   = 16;
    localparam int FRAME_SAMPLES = 1024;

    // floor(log2(FRAME_SAMPLES))
    localparam int FRAME_SHIFT = $clog2(FRAME_SAMPLES + 1) - 1;
    localparam int IDX_W       = $clog2(FRAME_SAMPLES);
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int ACC_W       = SQ_W + $clog2(FRAME_SAMPLES);
    // rescale of the mean to unsigned Q1.30
    localparam int SCALE_R     = (SAMPLE_BITS >= 16) ? 2 * (SAMPLE_BITS - 16) : 0;
    localparam int SCALE_L     = (SAMPLE_BITS < 16) ? 2 * (16 - SAMPLE_BITS) : 0;
    localparam int MEAN_W      = ACC_W + SCALE_L;

    localparam int ENERGY_W = 31;
    localparam int CNT_W    = 16;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = ENERGY_W'(1 << 30);
    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETECTION_ENABLED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEECH_LIMIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH_RUN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_QUIET_RUN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK_FRAMES  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_FOR_SILENCE = 3'd7;

    // register reset values
    localparam logic [ENERGY_W-1:0] RST_SILENCE_LIMIT     = 31'd1073742;
    localparam logic [ENERGY_W-1:0] RST_SPEECH_LIMIT      = 31'd2684355;
    localparam logic [CNT_W-1:0]    RST_MIN_SPEECH_RUN    = 16'd3;
    localparam logic [CNT_W-1:0]    RST_MIN_QUIET_RUN     = 16'd16;
    localparam logic [CNT_W-1:0]    RST_MAX_CHUNK_FRAMES  = 16'd500;
    localparam logic [CNT_W-1:0]    RST_QUIET_FOR_SILENCE = 16'd31;

    // chunk event codes
    typedef logic [1:0] t_event;
    localparam t_event EVT_NONE  = 2'd0;
    localparam t_event EVT_END   = 2'd1;
    localparam t_event EVT_SPLIT = 2'd2;

    // frame energy handed from the accumulator to the detector
    typedef struct packed {
        logic                valid;
        logic [ENERGY_W-1:0] energy;
    } t_frame;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

// ===== src/fevad_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fevad_accum
// Input register, squarer, frame accumulator and mean-square stage.
// ----------------------------------------------------------------------------
module fevad_accum (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_adv,
    input  wire logic                                 i_in_valid,
    input  wire logic signed [fevad_pkg::SAMPLE_BITS-1:0] i_sample,
    output fevad_pkg::t_frame                          o_frame
);
    import fevad_pkg::*;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_sq_valid;
    logic [SQ_W-1:0]               r_sq;
    logic [ACC_W-1:0]              r_sum;
    logic [IDX_W-1:0]              r_index;
    logic                          r_frame_valid;
    logic [ACC_W-1:0]              r_frame_sum;
    logic                          r_energy_valid;
    logic [ENERGY_W-1:0]           r_energy;

    logic signed [SQ_W-1:0] w_prod;
    logic [ACC_W-1:0]       w_sum_next;
    logic                   w_last;
    logic [MEAN_W-1:0]      w_mean;
    logic [ENERGY_W-1:0]    n_energy;

    assign w_prod     = r_sample * r_sample;
    assign w_sum_next = r_sum + ACC_W'(r_sq);
    assign w_last     = (r_index == IDX_W'(FRAME_SAMPLES - 1));

    always_comb begin
        w_mean = (MEAN_W'(r_frame_sum) >> (FRAME_SHIFT + SCALE_R)) << SCALE_L;
        if (w_mean > MEAN_W'(ENERGY_MAX)) begin
            n_energy = ENERGY_MAX;
        end else begin
            n_energy = w_mean[ENERGY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_sq_valid     <= 1'b0;
            r_sum          <= '0;
            r_index        <= '0;
            r_frame_valid  <= 1'b0;
            r_energy_valid <= 1'b0;
        end else if (i_adv) begin
            r_in_valid     <= i_in_valid;
            r_sq_valid     <= r_in_valid;
            r_frame_valid  <= r_sq_valid && w_last;
            r_energy_valid <= r_frame_valid;
            if (r_sq_valid) begin
                if (w_last) begin
                    r_sum   <= '0;
                    r_index <= '0;
                end else begin
                    r_sum   <= w_sum_next;
                    r_index <= r_index + IDX_W'(1);
                end
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sample    <= i_sample;
            r_sq        <= w_prod;
            r_frame_sum <= w_sum_next;
            r_energy    <= n_energy;
        end
    end

    assign o_frame.valid  = r_energy_valid;
    assign o_frame.energy = r_energy;

    a_energy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_energy_valid |-> (r_energy <= ENERGY_MAX))
        else $error("frame energy above saturation limit");

    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_valid |-> (r_index == '0))
        else $error("sample index not restarted at frame end");

    a_frame_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_frame_valid) |=> !r_frame_valid)
        else $error("frame ends in consecutive cycles");

endmodule
`default_nettype wire

// ===== src/fevad_vad.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fevad_vad
// Configuration registers, quiet counter, speech state machine, result register.
// ----------------------------------------------------------------------------
module fevad_vad (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_adv,
    input  wire fevad_pkg::t_frame                    i_frame,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [fevad_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fevad_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [fevad_pkg::ENERGY_W-1:0]            o_frame_energy,
    output logic                                      o_speaking,
    output logic [1:0]                                o_chunk_event,
    output logic                                      o_silence_reached
);
    import fevad_pkg::*;

    // configuration
    logic                r_continuous, n_continuous;
    logic                r_detect, n_detect;
    logic [ENERGY_W-1:0] r_silence_limit, n_silence_limit;
    logic [ENERGY_W-1:0] r_speech_limit, n_speech_limit;
    logic [CNT_W-1:0]    r_min_speech, n_min_speech;
    logic [CNT_W-1:0]    r_min_quiet, n_min_quiet;
    logic [CNT_W-1:0]    r_max_chunk, n_max_chunk;
    logic [CNT_W-1:0]    r_quiet_limit, n_quiet_limit;

    // detector state
    logic             r_in_speech, n_in_speech;
    logic [CNT_W-1:0] r_speech_run, n_speech_run;
    logic [CNT_W-1:0] r_quiet_run, n_quiet_run;
    logic [CNT_W-1:0] r_plain_count, n_plain_count;
    logic [CNT_W-1:0] r_chunk_len, n_chunk_len;
    t_event           n_event;
    logic             w_speech;
    logic             w_frame;

    // result register
    logic                r_out_valid;
    logic [ENERGY_W-1:0] r_out_energy;
    logic                r_out_speaking;
    t_event              r_out_event;
    logic                r_out_silence;
    logic                w_load;

    assign w_frame  = i_frame.valid && i_adv;
    assign w_speech = (i_frame.energy > r_speech_limit);
    assign w_load   = !r_out_valid || i_out_ready;

    always_comb begin
        n_continuous    = r_continuous;
        n_detect        = r_detect;
        n_silence_limit = r_silence_limit;
        n_speech_limit  = r_speech_limit;
        n_min_speech    = r_min_speech;
        n_min_quiet     = r_min_quiet;
        n_max_chunk     = r_max_chunk;
        n_quiet_limit   = r_quiet_limit;
        n_in_speech     = r_in_speech;
        n_speech_run    = r_speech_run;
        n_quiet_run     = r_quiet_run;
        n_plain_count   = r_plain_count;
        n_chunk_len     = r_chunk_len;
        n_event         = EVT_NONE;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CONTINUOUS_MODE: begin
                    n_continuous = i_cfg_data[0];
                    if (r_detect) begin
                        n_in_speech = 1'b0;
                        n_chunk_len = '0;
                        if (i_cfg_data[0]) begin
                            n_speech_run = '0;
                            n_quiet_run  = '0;
                        end
                    end
                end
                REG_DETECTION_ENABLED: n_detect        = i_cfg_data[0];
                REG_SILENCE_LIMIT:     n_silence_limit = i_cfg_data[ENERGY_W-1:0];
                REG_SPEECH_LIMIT:      n_speech_limit  = i_cfg_data[ENERGY_W-1:0];
                REG_MIN_SPEECH_RUN:    n_min_speech    = i_cfg_data[CNT_W-1:0];
                REG_MIN_QUIET_RUN:     n_min_quiet     = i_cfg_data[CNT_W-1:0];
                REG_MAX_CHUNK_FRAMES:  n_max_chunk     = i_cfg_data[CNT_W-1:0];
                REG_QUIET_FOR_SILENCE: n_quiet_limit   = i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end else if (w_frame) begin
            if (!r_continuous) begin
                if (i_frame.energy < r_silence_limit) begin
                    n_plain_count = sat_inc(r_plain_count);
                end else begin
                    n_plain_count = '0;
                end
            end else if (r_detect) begin
                if (!r_in_speech) begin
                    if (w_speech) begin
                        n_speech_run = sat_inc(r_speech_run);
                        if (n_speech_run >= r_min_speech) begin
                            n_in_speech  = 1'b1;
                            n_speech_run = '0;
                            n_quiet_run  = '0;
                            n_chunk_len  = '0;
                        end
                    end else begin
                        n_speech_run = '0;
                    end
                end else begin
                    n_chunk_len = sat_inc(r_chunk_len);
                    if (!w_speech) begin
                        n_quiet_run = sat_inc(r_quiet_run);
                        if (n_quiet_run >= r_min_quiet) begin
                            n_in_speech  = 1'b0;
                            n_quiet_run  = '0;
                            n_speech_run = '0;
                            n_chunk_len  = '0;
                            n_event      = EVT_END;
                        end
                    end else begin
                        n_quiet_run = '0;
                        if (n_chunk_len >= r_max_chunk) begin
                            n_event     = EVT_SPLIT;
                            n_chunk_len = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_continuous    <= 1'b0;
            r_detect        <= 1'b1;
            r_silence_limit <= RST_SILENCE_LIMIT;
            r_speech_limit  <= RST_SPEECH_LIMIT;
            r_min_speech    <= RST_MIN_SPEECH_RUN;
            r_min_quiet     <= RST_MIN_QUIET_RUN;
            r_max_chunk     <= RST_MAX_CHUNK_FRAMES;
            r_quiet_limit   <= RST_QUIET_FOR_SILENCE;
            r_in_speech     <= 1'b0;
            r_speech_run    <= '0;
            r_quiet_run     <= '0;
            r_plain_count   <= '0;
            r_chunk_len     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_continuous    <= n_continuous;
            r_detect        <= n_detect;
            r_silence_limit <= n_silence_limit;
            r_speech_limit  <= n_speech_limit;
            r_min_speech    <= n_min_speech;
            r_min_quiet     <= n_min_quiet;
            r_max_chunk     <= n_max_chunk;
            r_quiet_limit   <= n_quiet_limit;
            r_in_speech     <= n_in_speech;
            r_speech_run    <= n_speech_run;
            r_quiet_run     <= n_quiet_run;
            r_plain_count   <= n_plain_count;
            r_chunk_len     <= n_chunk_len;
            if (w_load) begin
                r_out_valid <= i_frame.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_energy   <= i_frame.energy;
            r_out_speaking <= n_in_speech;
            r_out_event    <= n_event;
            r_out_silence  <= (n_plain_count >= r_quiet_limit);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_energy    = r_out_energy;
    assign o_speaking        = r_out_speaking;
    assign o_chunk_event     = r_out_event;
    assign o_silence_reached = r_out_silence;

    a_end_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EVT_END) |-> !r_out_speaking)
        else $error("chunk end reported while speaking");

    a_split_is_speaking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EVT_SPLIT) |-> r_out_speaking)
        else $error("chunk split reported while silent");

    a_no_lost_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frame.valid && !i_adv) |-> (r_out_valid && !i_out_ready))
        else $error("frame held without a blocked result");

endmodule
`default_nettype wire

// ===== src/frame_energy_voice_activity_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_energy_voice_activity_detector
// Frame mean-square energy with quiet counting and speech chunk detection.
// ----------------------------------------------------------------------------
// channel  direction  handshake                  payload
// in       sink       i_in_valid / o_in_ready    i_sample
// out      source     o_out_valid / i_out_ready  o_frame_energy, o_speaking,
//                                                o_chunk_event, o_silence_reached
// cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one sample per clock while o_in_ready is high; one result per FRAME_SAMPLES samples
// the result of a frame is registered after its last sample is accepted, in order through
//   the input register, squarer, accumulator, mean stage and result register
// synchronous active-low reset clears all control state and loads register defaults
// input stalls only when a finished frame meets a result not yet taken
// ----------------------------------------------------------------------------
module frame_energy_voice_activity_detector (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_ready,
    input  wire logic signed [fevad_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_ready,
    output logic [fevad_pkg::ENERGY_W-1:0]                o_frame_energy,
    output logic                                          o_speaking,
    output logic [1:0]                                    o_chunk_event,
    output logic                                          o_silence_reached,
    input  wire logic                                     i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  wire logic [fevad_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [fevad_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import fevad_pkg::*;

    t_frame w_frame;
    logic   w_adv;
    logic   w_out_valid;

    // pipeline moves unless a frame result waits on a blocked output
    assign w_adv       = !w_frame.valid || !w_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = w_out_valid;

    fevad_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_in_valid (i_in_valid),
        .i_sample   (i_sample),
        .o_frame    (w_frame)
    );

    fevad_vad u_vad (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (w_adv),
        .i_frame           (w_frame),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (w_out_valid),
        .i_out_ready       (i_out_ready),
        .o_frame_energy    (o_frame_energy),
        .o_speaking        (o_speaking),
        .o_chunk_event     (o_chunk_event),
        .o_silence_reached (o_silence_reached)
    );

endmodule
`default_nettype wire
